FILE: hdl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared constants, codes and types for the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

	// pool geometry
	localparam int NUM_BLOCKS = 16;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	// links and counts must be able to hold NUM_BLOCKS itself
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

	// fixed field widths on the ports
	localparam int KIND_FW    = 1;
	localparam int BIDX_FW    = 4;
	localparam int STAT_FW    = 2;
	localparam int GIDX_FW    = 4;
	localparam int FCNT_FW    = 5;
	localparam int PEAK_FW    = 5;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// request kinds
	localparam logic [KIND_FW-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_FW-1:0] KIND_FREE  = 1'b1;

	// result status codes
	localparam logic [STAT_FW-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_FW-1:0] STAT_EMPTY  = 2'd1;
	localparam logic [STAT_FW-1:0] STAT_REJECT = 2'd2;

	// controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic pop;
		logic push;
		logic rej_empty;
		logic rej_full;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic can_pop;
		logic can_push;
	} dp_stat_t;

endpackage

FILE: hdl/fbfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Controller: handshakes on both sides and issues one datapath command per
// accepted transaction.
// ----------------------------------------------------------------------------
module fbfl_ctrl import fbfl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [KIND_FW-1:0] kind,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  dp_stat_t           stat,
	output dp_cmd_t            cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, handshakes and commands
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		accept   = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				accept   = s_tvalid;
				if (accept) begin
					if (kind == KIND_ALLOC) begin
						cmd.pop       = stat.can_pop;
						cmd.rej_empty = !stat.can_pop;
					end else begin
						cmd.push     = stat.can_push;
						cmd.rej_full = !stat.can_push;
					end
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/fbfl_dp.sv
// ----------------------------------------------------------------------------
// fbfl_dp
// Datapath: link store, head pointer, free and peak counters, result register.
// ----------------------------------------------------------------------------
module fbfl_dp import fbfl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [BIDX_FW-1:0] block_index,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic [STAT_FW-1:0] status,
	output logic [GIDX_FW-1:0] granted_index,
	output logic [FCNT_FW-1:0] free_count,
	output logic [PEAK_FW-1:0] peak_used
);

	logic [CNT_W-1:0] link_q [NUM_BLOCKS];
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] peak_q;

	logic [CNT_W-1:0] free_d;
	logic [CNT_W-1:0] peak_d;
	logic [CNT_W-1:0] used_d;
	logic [IDX_W-1:0] head_addr;
	logic [IDX_W-1:0] push_addr;
	logic             head_ok;
	logic             idx_ok;

	logic [STAT_FW-1:0] status_q;
	logic [GIDX_FW-1:0] granted_q;
	logic [FCNT_FW-1:0] free_out_q;
	logic [PEAK_FW-1:0] peak_out_q;

	// status towards the controller
	always_comb begin
		head_ok      = head_q < CNT_W'(NUM_BLOCKS);
		idx_ok       = 32'(block_index) < NUM_BLOCKS;
		head_addr    = IDX_W'(head_q);
		push_addr    = IDX_W'(block_index);
		stat.can_pop = (free_q != '0) && head_ok;
		stat.can_push = (free_q < CNT_W'(NUM_BLOCKS)) && idx_ok;
	end

	// counter updates
	always_comb begin
		free_d = free_q;
		peak_d = peak_q;
		used_d = CNT_W'(NUM_BLOCKS) - (free_q - CNT_W'(1));
		if (cmd.pop) begin
			free_d = free_q - CNT_W'(1);
			if (used_d > peak_q) begin
				peak_d = used_d;
			end
		end else if (cmd.push) begin
			free_d = free_q + CNT_W'(1);
		end
	end

	// list state, link entry i starts out naming i plus one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				link_q[i] <= CNT_W'(i + 1);
			end
			head_q <= '0;
			free_q <= CNT_W'(NUM_BLOCKS);
			peak_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q <= link_q[head_addr];
			end else if (cmd.push) begin
				link_q[push_addr] <= head_q;
				head_q            <= CNT_W'(block_index);
			end
			free_q <= free_d;
			peak_q <= peak_d;
		end
	end

	// result register, loaded on every transaction
	always_ff @(posedge clk) begin
		if (cmd.pop || cmd.push || cmd.rej_empty || cmd.rej_full) begin
			if (cmd.rej_empty) begin
				status_q <= STAT_EMPTY;
			end else if (cmd.rej_full) begin
				status_q <= STAT_REJECT;
			end else begin
				status_q <= STAT_OK;
			end
			granted_q  <= cmd.pop ? GIDX_FW'(head_q) : '0;
			free_out_q <= FCNT_FW'(free_d);
			peak_out_q <= PEAK_FW'(peak_d);
		end
	end

	assign status        = status_q;
	assign granted_index = granted_q;
	assign free_count    = free_out_q;
	assign peak_used     = peak_out_q;

endmodule

FILE: hdl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Hands out and takes back equal blocks of a pool by index, using a LIFO free
// list. Each request (tuser = kind, tdata = block index) gives one result
// with status, granted index, free count and peak usage. The result of a
// request is registered and shows in the cycle after it is taken; the block
// then waits for the result transaction before taking another request. The
// pace is set by the single result register shared by all requests. The link
// store is in flip-flops and is set up by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator import fbfl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [3:0] block_index, [7:4] zero
	input  logic [KIND_FW-1:0]    s_tuser,  // [0] kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // [1:0] status, [5:2] granted_index,
	                                        // [10:6] free_count, [15:11] peak_used
);

	dp_cmd_t            cmd;
	dp_stat_t           stat;
	logic [STAT_FW-1:0] status;
	logic [GIDX_FW-1:0] granted_index;
	logic [FCNT_FW-1:0] free_count;
	logic [PEAK_FW-1:0] peak_used;

	// controller
	fbfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	fbfl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.block_index   (s_tdata[BIDX_FW-1:0]),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.granted_index (granted_index),
		.free_count    (free_count),
		.peak_used     (peak_used)
	);

	// result packing
	assign m_tdata = {peak_used, free_count, granted_index, status};

endmodule

FILE: hdl/fbfl_checker.sv
// ----------------------------------------------------------------------------
// fbfl_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbfl_checker import fbfl_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [KIND_FW-1:0]    s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// one transaction in flight: never ready for a request while a result waits
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request taken while a result is pending");

	// every request gives a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("no result after a request");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	// a REJECT result carries index zero, and no unused status code appears
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[1:0] == STAT_OK) || (m_tdata[1:0] == STAT_EMPTY)
			|| ((m_tdata[1:0] == STAT_REJECT) && (m_tdata[5:2] == 4'd0))))
		else $error("bad status or index in result");

	// a free never grants a block
	a_free_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == KIND_FREE)) |=> (m_tdata[5:2] == 4'd0))
		else $error("free returned a granted index");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
